### rtl/core/ttf_pkg.sv
package ttf_pkg;

    localparam int OUT_FRAC_BITS_DEF = 14;

    localparam int POS_W  = 32;
    localparam int TEX_W  = 16;
    localparam int OUT_W  = 16;
    localparam int MAG_W  = 30;
    localparam int ROOT_W = 31;
    localparam int SUM_W  = 62;

    localparam logic [1:0] CORNER_FIRST  = 2'd0;
    localparam logic [1:0] CORNER_SECOND = 2'd1;
    localparam logic [1:0] CORNER_CLOSE  = 2'd2;

    typedef enum logic {
        RD_SQRT,
        RD_DIV
    } rd_mode_t;

    typedef struct packed {
        logic     start;
        rd_mode_t mode;
    } rd_cmd_t;

    typedef enum logic [1:0] {
        K_DET,
        K_TAN,
        K_BIN,
        K_NRM
    } ttf_kind_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MUL,
        ST_ACC,
        ST_ABS,
        ST_MAX,
        ST_LZC,
        ST_SHIFT,
        ST_SQRT_GO,
        ST_SQRT_WAIT,
        ST_DIV_GO,
        ST_DIV_WAIT,
        ST_DONE
    } ttf_state_t;

endpackage

### rtl/core/ttf_rootdiv.sv
module ttf_rootdiv #(
    parameter int OUT_FRAC_BITS = ttf_pkg::OUT_FRAC_BITS_DEF
) (
    input  logic                                      aclk,
    input  logic                                      aresetn,
    input  ttf_pkg::rd_cmd_t                          cmd,
    input  logic [ttf_pkg::SUM_W-1:0]                 radicand,
    input  logic [ttf_pkg::MAG_W+OUT_FRAC_BITS:0]     numer,
    input  logic [ttf_pkg::ROOT_W-1:0]                divisor,
    output logic                                      busy,
    output logic [ttf_pkg::ROOT_W-1:0]                result
);
    import ttf_pkg::*;

    localparam int NUM_W    = MAG_W + OUT_FRAC_BITS + 1;
    localparam int WORK_W   = (NUM_W > SUM_W) ? NUM_W : SUM_W;
    localparam int Q_BITS   = OUT_FRAC_BITS + 1;
    localparam int MAX_ITER = (ROOT_W > Q_BITS) ? ROOT_W : Q_BITS;
    localparam int CNT_W    = $clog2(MAX_ITER + 1);
    localparam int REM_W    = ROOT_W + 5;

    rd_mode_t            mode_reg, mode_next;
    logic [CNT_W-1:0]    cnt_reg, cnt_next;
    logic [REM_W-1:0]    rem_reg, rem_next;
    logic [WORK_W-1:0]   work_reg, work_next;
    logic [ROOT_W-1:0]   res_reg, res_next;
    logic [REM_W-1:0]    rem_shift;
    logic [REM_W-1:0]    trial;

    always_comb begin
        mode_next = mode_reg;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        work_next = work_reg;
        res_next  = res_reg;
        rem_shift = '0;
        trial     = '0;
        if (cmd.start) begin
            mode_next = cmd.mode;
            res_next  = '0;
            if (cmd.mode == RD_SQRT) begin
                rem_next  = '0;
                work_next = WORK_W'(radicand) << (WORK_W - SUM_W);
                cnt_next  = CNT_W'(ROOT_W);
            end else begin
                rem_next  = REM_W'(numer >> Q_BITS);
                work_next = WORK_W'(numer) << (WORK_W - Q_BITS);
                cnt_next  = CNT_W'(Q_BITS);
            end
        end else if (cnt_reg != '0) begin
            cnt_next = cnt_reg - 1'b1;
            if (mode_reg == RD_SQRT) begin
                rem_shift = {rem_reg[REM_W-3:0], work_reg[WORK_W-1 -: 2]};
                trial     = REM_W'({res_reg, 2'b01});
                work_next = work_reg << 2;
            end else begin
                rem_shift = {rem_reg[REM_W-2:0], work_reg[WORK_W-1]};
                trial     = REM_W'(divisor);
                work_next = work_reg << 1;
            end
            if (rem_shift >= trial) begin
                rem_next = rem_shift - trial;
                res_next = {res_reg[ROOT_W-2:0], 1'b1};
            end else begin
                rem_next = rem_shift;
                res_next = {res_reg[ROOT_W-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
        end else begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        mode_reg <= mode_next;
        rem_reg  <= rem_next;
        work_reg <= work_next;
        res_reg  <= res_next;
    end

    assign busy   = (cnt_reg != '0);
    assign result = res_reg;

endmodule

### rtl/core/triangle_tangent_frame_top.sv
// Per-triangle tangent frame.
// Input channel (s_valid/s_ready): one triangle corner per transfer. Corners 0
// and 1 are stored. Corner 2 closes the triangle and starts the frame
// computation; corner 3 is dropped.
// Result channel (m_valid/m_ready): one transfer per corner 2 carrying unit
// tangent, binormal and normal in Q1.OUT_FRAC_BITS, or all zero with
// m_degenerate set.
// A degenerate triangle finishes earlier than a full one. The time is set
// by the shared bit-serial root/divide unit: one 31-step square root per vector
// and nine OUT_FRAC_BITS+1 step divisions, plus 29 passes through the single
// 33x33 multiplier. s_ready is low while a triangle is computed.
// A finished result waits in the output register while the receiver stalls;
// the next corners are still taken, and a following triangle holds in its last
// state until the output register is free.
// Reset clears the sequencer, the output valid and the stored corners 0 and 1.
module triangle_tangent_frame_top #(
    parameter int OUT_FRAC_BITS = ttf_pkg::OUT_FRAC_BITS_DEF
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  logic [1:0]                           s_corner,
    input  logic signed [ttf_pkg::POS_W-1:0]     s_pos_x,
    input  logic signed [ttf_pkg::POS_W-1:0]     s_pos_y,
    input  logic signed [ttf_pkg::POS_W-1:0]     s_pos_z,
    input  logic signed [ttf_pkg::TEX_W-1:0]     s_tex_u,
    input  logic signed [ttf_pkg::TEX_W-1:0]     s_tex_v,
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output logic signed [ttf_pkg::OUT_W-1:0]     m_tangent_x,
    output logic signed [ttf_pkg::OUT_W-1:0]     m_tangent_y,
    output logic signed [ttf_pkg::OUT_W-1:0]     m_tangent_z,
    output logic signed [ttf_pkg::OUT_W-1:0]     m_bitangent_x,
    output logic signed [ttf_pkg::OUT_W-1:0]     m_bitangent_y,
    output logic signed [ttf_pkg::OUT_W-1:0]     m_bitangent_z,
    output logic signed [ttf_pkg::OUT_W-1:0]     m_normal_x,
    output logic signed [ttf_pkg::OUT_W-1:0]     m_normal_y,
    output logic signed [ttf_pkg::OUT_W-1:0]     m_normal_z,
    output logic                                 m_degenerate
);
    import ttf_pkg::*;

    localparam int UW     = OUT_FRAC_BITS + 2;
    localparam int E_W    = POS_W + 1;
    localparam int D_W    = TEX_W + 1;
    localparam int OP_W   = 33;
    localparam int PROD_W = 2 * OP_W;
    localparam int ACC_W  = 64;
    localparam int VEC_W  = 63;
    localparam int NUM_W  = MAG_W + OUT_FRAC_BITS + 1;

    function automatic logic [OUT_W-1:0] to_out(input logic signed [UW-1:0] v);
        logic signed [31:0] w;
        w = 32'(v);
        return w[OUT_W-1:0];
    endfunction

    ttf_state_t state_reg, state_next;
    ttf_kind_t  kind_reg, kind_next;
    logic [1:0] comp_reg, comp_next;
    logic       step_reg, step_next;
    logic       sq_reg, sq_next;
    logic [2:0] lzs_reg, lzs_next;
    logic       degen_reg, degen_next;
    logic       m_valid_reg, m_valid_next;
    logic       out_load;

    logic signed [POS_W-1:0] hp0_reg [3];
    logic signed [POS_W-1:0] hp1_reg [3];
    logic signed [POS_W-1:0] p2_reg  [3];
    logic signed [TEX_W-1:0] ht0_reg [2];
    logic signed [TEX_W-1:0] ht1_reg [2];
    logic signed [TEX_W-1:0] t2_reg  [2];

    logic signed [E_W-1:0]    e1 [3];
    logic signed [E_W-1:0]    e2 [3];
    logic signed [D_W-1:0]    d1u, d1v, d2u, d2v;

    logic signed [OP_W-1:0]   op_a, op_b;
    logic signed [PROD_W-1:0] prod_next, prod_reg;
    logic signed [ACC_W-1:0]  acc_reg, acc_sum, prod64, vec_val;
    logic                     det_neg_reg;
    logic signed [VEC_W-1:0]  cvec_reg [3];
    logic [VEC_W-1:0]         mag_reg [3];
    logic                     sign_reg [3];
    logic [VEC_W-1:0]         mx, mx01;
    logic [63:0]              probe_reg;
    logic [5:0]               lz_reg;
    logic [MAG_W-1:0]         msc_reg [3];
    logic [MAG_W-1:0]         msc_val;
    logic [ROOT_W-1:0]        s_reg;
    logic signed [UW-1:0]     ut_reg [3];
    logic signed [UW-1:0]     ub_reg [3];
    logic signed [UW-1:0]     un_reg [3];
    logic signed [UW-1:0]     q_val;

    logic [OUT_W-1:0]         out_t_reg [3];
    logic [OUT_W-1:0]         out_b_reg [3];
    logic [OUT_W-1:0]         out_n_reg [3];
    logic                     out_d_reg;

    rd_cmd_t                  rd_cmd;
    logic [NUM_W-1:0]         rd_numer;
    logic                     rd_busy;
    logic [ROOT_W-1:0]        rd_result;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            e1[i] = E_W'(hp1_reg[i]) - E_W'(hp0_reg[i]);
            e2[i] = E_W'(p2_reg[i]) - E_W'(hp0_reg[i]);
        end
        d1u = D_W'(ht1_reg[0]) - D_W'(ht0_reg[0]);
        d1v = D_W'(ht1_reg[1]) - D_W'(ht0_reg[1]);
        d2u = D_W'(t2_reg[0]) - D_W'(ht0_reg[0]);
        d2v = D_W'(t2_reg[1]) - D_W'(ht0_reg[1]);
    end

    // multiplier operand select
    always_comb begin
        op_a = '0;
        op_b = '0;
        if (sq_reg) begin
            op_a = OP_W'($signed({1'b0, msc_reg[comp_reg]}));
            op_b = op_a;
        end else begin
            unique case (kind_reg)
                K_DET: begin
                    op_a = step_reg ? OP_W'(d2u) : OP_W'(d1u);
                    op_b = step_reg ? OP_W'(d1v) : OP_W'(d2v);
                end
                K_TAN: begin
                    op_a = step_reg ? OP_W'(d1v) : OP_W'(d2v);
                    op_b = step_reg ? OP_W'(e2[comp_reg]) : OP_W'(e1[comp_reg]);
                end
                K_BIN: begin
                    op_a = step_reg ? OP_W'(d2u) : OP_W'(d1u);
                    op_b = step_reg ? OP_W'(e1[comp_reg]) : OP_W'(e2[comp_reg]);
                end
                K_NRM: begin
                    unique case (comp_reg)
                        2'd0: begin
                            op_a = step_reg ? OP_W'(ut_reg[2]) : OP_W'(ut_reg[1]);
                            op_b = step_reg ? OP_W'(ub_reg[1]) : OP_W'(ub_reg[2]);
                        end
                        2'd1: begin
                            op_a = step_reg ? OP_W'(ut_reg[0]) : OP_W'(ut_reg[2]);
                            op_b = step_reg ? OP_W'(ub_reg[2]) : OP_W'(ub_reg[0]);
                        end
                        default: begin
                            op_a = step_reg ? OP_W'(ut_reg[1]) : OP_W'(ut_reg[0]);
                            op_b = step_reg ? OP_W'(ub_reg[0]) : OP_W'(ub_reg[1]);
                        end
                    endcase
                end
                default: begin
                    op_a = '0;
                    op_b = '0;
                end
            endcase
        end
    end

    assign prod_next = op_a * op_b;
    assign prod64    = $signed(prod_reg[ACC_W-1:0]);

    always_comb begin
        if (sq_reg) begin
            acc_sum = (comp_reg == 2'd0) ? prod64 : acc_reg + prod64;
        end else begin
            acc_sum = step_reg ? acc_reg - prod64 : prod64;
        end
        vec_val = (kind_reg != K_NRM && det_neg_reg) ? -acc_sum : acc_sum;
    end

    always_comb begin
        mx01 = (mag_reg[0] > mag_reg[1]) ? mag_reg[0] : mag_reg[1];
        mx   = (mx01 > mag_reg[2]) ? mx01 : mag_reg[2];
    end

    always_comb begin
        if (lz_reg < 6'd34) begin
            msc_val = MAG_W'(mag_reg[comp_reg] >> (6'd34 - lz_reg));
        end else begin
            msc_val = MAG_W'(mag_reg[comp_reg] << (lz_reg - 6'd34));
        end
    end

    assign rd_numer = (NUM_W'(msc_reg[comp_reg]) << OUT_FRAC_BITS) + NUM_W'(s_reg >> 1);
    assign q_val = sign_reg[comp_reg] ? -UW'(rd_result[OUT_FRAC_BITS:0])
                                      : UW'(rd_result[OUT_FRAC_BITS:0]);

    // sequencer
    always_comb begin
        state_next   = state_reg;
        kind_next    = kind_reg;
        comp_next    = comp_reg;
        step_next    = step_reg;
        sq_next      = sq_reg;
        lzs_next     = lzs_reg;
        degen_next   = degen_reg;
        m_valid_next = m_valid_reg && !m_ready;
        rd_cmd       = '{start: 1'b0, mode: RD_SQRT};
        out_load     = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid && s_corner == CORNER_CLOSE) begin
                    state_next = ST_MUL;
                    kind_next  = K_DET;
                    comp_next  = 2'd0;
                    step_next  = 1'b0;
                    sq_next    = 1'b0;
                    degen_next = 1'b0;
                end
            end
            ST_MUL: state_next = ST_ACC;
            ST_ACC: begin
                if (sq_reg) begin
                    if (comp_reg == 2'd2) begin
                        state_next = ST_SQRT_GO;
                    end else begin
                        comp_next  = comp_reg + 2'd1;
                        state_next = ST_MUL;
                    end
                end else if (!step_reg) begin
                    step_next  = 1'b1;
                    state_next = ST_MUL;
                end else begin
                    step_next = 1'b0;
                    if (kind_reg == K_DET) begin
                        if (acc_sum == '0) begin
                            degen_next = 1'b1;
                            state_next = ST_DONE;
                        end else begin
                            kind_next  = K_TAN;
                            comp_next  = 2'd0;
                            state_next = ST_MUL;
                        end
                    end else if (comp_reg == 2'd2) begin
                        state_next = ST_ABS;
                    end else begin
                        comp_next  = comp_reg + 2'd1;
                        state_next = ST_MUL;
                    end
                end
            end
            ST_ABS: state_next = ST_MAX;
            ST_MAX: begin
                if (mx == '0) begin
                    degen_next = 1'b1;
                    state_next = ST_DONE;
                end else begin
                    lzs_next   = 3'd0;
                    state_next = ST_LZC;
                end
            end
            ST_LZC: begin
                lzs_next = lzs_reg + 3'd1;
                if (lzs_reg == 3'd5) begin
                    comp_next  = 2'd0;
                    state_next = ST_SHIFT;
                end
            end
            ST_SHIFT: begin
                if (comp_reg == 2'd2) begin
                    sq_next    = 1'b1;
                    comp_next  = 2'd0;
                    state_next = ST_MUL;
                end else begin
                    comp_next = comp_reg + 2'd1;
                end
            end
            ST_SQRT_GO: begin
                rd_cmd     = '{start: 1'b1, mode: RD_SQRT};
                state_next = ST_SQRT_WAIT;
            end
            ST_SQRT_WAIT: begin
                if (!rd_busy) begin
                    comp_next  = 2'd0;
                    state_next = ST_DIV_GO;
                end
            end
            ST_DIV_GO: begin
                rd_cmd     = '{start: 1'b1, mode: RD_DIV};
                state_next = ST_DIV_WAIT;
            end
            ST_DIV_WAIT: begin
                if (!rd_busy) begin
                    if (comp_reg == 2'd2) begin
                        if (kind_reg == K_NRM) begin
                            state_next = ST_DONE;
                        end else begin
                            kind_next  = (kind_reg == K_TAN) ? K_BIN : K_NRM;
                            comp_next  = 2'd0;
                            step_next  = 1'b0;
                            sq_next    = 1'b0;
                            state_next = ST_MUL;
                        end
                    end else begin
                        comp_next  = comp_reg + 2'd1;
                        state_next = ST_DIV_GO;
                    end
                end
            end
            ST_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    out_load     = 1'b1;
                    m_valid_next = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            kind_reg    <= K_DET;
            comp_reg    <= 2'd0;
            step_reg    <= 1'b0;
            sq_reg      <= 1'b0;
            lzs_reg     <= 3'd0;
            degen_reg   <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            kind_reg    <= kind_next;
            comp_reg    <= comp_next;
            step_reg    <= step_next;
            sq_reg      <= sq_next;
            lzs_reg     <= lzs_next;
            degen_reg   <= degen_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hp0_reg <= '{default: '0};
            hp1_reg <= '{default: '0};
            ht0_reg <= '{default: '0};
            ht1_reg <= '{default: '0};
        end else if (s_valid && s_ready) begin
            if (s_corner == CORNER_FIRST) begin
                hp0_reg <= '{s_pos_x, s_pos_y, s_pos_z};
                ht0_reg <= '{s_tex_u, s_tex_v};
            end
            if (s_corner == CORNER_SECOND) begin
                hp1_reg <= '{s_pos_x, s_pos_y, s_pos_z};
                ht1_reg <= '{s_tex_u, s_tex_v};
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready && s_corner == CORNER_CLOSE) begin
            p2_reg <= '{s_pos_x, s_pos_y, s_pos_z};
            t2_reg <= '{s_tex_u, s_tex_v};
        end
        if (state_reg == ST_MUL) begin
            prod_reg <= prod_next;
        end
        if (state_reg == ST_ACC) begin
            acc_reg <= acc_sum;
            if (!sq_reg && step_reg) begin
                if (kind_reg == K_DET) begin
                    det_neg_reg <= acc_sum < 0;
                end else begin
                    cvec_reg[comp_reg] <= VEC_W'(vec_val);
                end
            end
        end
        if (state_reg == ST_ABS) begin
            for (int i = 0; i < 3; i++) begin
                sign_reg[i] <= cvec_reg[i][VEC_W-1];
                mag_reg[i]  <= cvec_reg[i][VEC_W-1] ? VEC_W'(-cvec_reg[i])
                                                    : VEC_W'(cvec_reg[i]);
            end
        end
        if (state_reg == ST_MAX) begin
            probe_reg <= {1'b0, mx};
            lz_reg    <= 6'd0;
        end
        if (state_reg == ST_LZC) begin
            unique case (lzs_reg)
                3'd0: if (probe_reg[63:32] == '0) begin
                    probe_reg <= probe_reg << 32;
                    lz_reg    <= lz_reg + 6'd32;
                end
                3'd1: if (probe_reg[63:48] == '0) begin
                    probe_reg <= probe_reg << 16;
                    lz_reg    <= lz_reg + 6'd16;
                end
                3'd2: if (probe_reg[63:56] == '0) begin
                    probe_reg <= probe_reg << 8;
                    lz_reg    <= lz_reg + 6'd8;
                end
                3'd3: if (probe_reg[63:60] == '0) begin
                    probe_reg <= probe_reg << 4;
                    lz_reg    <= lz_reg + 6'd4;
                end
                3'd4: if (probe_reg[63:62] == '0) begin
                    probe_reg <= probe_reg << 2;
                    lz_reg    <= lz_reg + 6'd2;
                end
                default: if (!probe_reg[63]) begin
                    probe_reg <= probe_reg << 1;
                    lz_reg    <= lz_reg + 6'd1;
                end
            endcase
        end
        if (state_reg == ST_SHIFT) begin
            msc_reg[comp_reg] <= msc_val;
        end
        if (state_reg == ST_SQRT_WAIT && !rd_busy) begin
            s_reg <= rd_result;
        end
        if (state_reg == ST_DIV_WAIT && !rd_busy) begin
            unique case (kind_reg)
                K_TAN:   ut_reg[comp_reg] <= q_val;
                K_BIN:   ub_reg[comp_reg] <= q_val;
                K_NRM:   un_reg[comp_reg] <= q_val;
                default: ;
            endcase
        end
        if (out_load) begin
            for (int i = 0; i < 3; i++) begin
                out_t_reg[i] <= degen_reg ? '0 : to_out(ut_reg[i]);
                out_b_reg[i] <= degen_reg ? '0 : to_out(ub_reg[i]);
                out_n_reg[i] <= degen_reg ? '0 : to_out(un_reg[i]);
            end
            out_d_reg <= degen_reg;
        end
    end

    ttf_rootdiv #(
        .OUT_FRAC_BITS(OUT_FRAC_BITS)
    ) u_rootdiv (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cmd     (rd_cmd),
        .radicand(acc_reg[SUM_W-1:0]),
        .numer   (rd_numer),
        .divisor (s_reg),
        .busy    (rd_busy),
        .result  (rd_result)
    );

    assign s_ready       = (state_reg == ST_IDLE);
    assign m_valid       = m_valid_reg;
    assign m_tangent_x   = out_t_reg[0];
    assign m_tangent_y   = out_t_reg[1];
    assign m_tangent_z   = out_t_reg[2];
    assign m_bitangent_x = out_b_reg[0];
    assign m_bitangent_y = out_b_reg[1];
    assign m_bitangent_z = out_b_reg[2];
    assign m_normal_x    = out_n_reg[0];
    assign m_normal_y    = out_n_reg[1];
    assign m_normal_z    = out_n_reg[2];
    assign m_degenerate  = out_d_reg;

`ifndef SYNTHESIS
    a_busy_not_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        rd_busy |-> !s_ready)
        else $error("root/divide unit busy while input is ready");

    a_degen_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_degenerate) |-> (m_tangent_x == '0 && m_bitangent_y == '0
                                       && m_normal_z == '0))
        else $error("degenerate result carries nonzero vector");

    a_valid_from_done: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> $past(state_reg == ST_DONE))
        else $error("result raised outside the done state");
`endif

endmodule

### tb/triangle_tangent_frame_top_tb.sv
module triangle_tangent_frame_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import ttf_pkg::*;

    localparam int FRAC = OUT_FRAC_BITS_DEF;
    localparam int CYCLE_LIMIT = 1000000;
    localparam logic [1:0] CORNER_DROPPED = 2'd3;

    typedef longint vec3_t [3];

    typedef struct {
        logic signed [OUT_W-1:0] comp [9];
        logic                    degen;
    } frame_t;

    logic aclk;
    logic aresetn;
    logic s_valid;
    logic s_ready;
    logic [1:0] s_corner;
    logic signed [POS_W-1:0] s_pos_x, s_pos_y, s_pos_z;
    logic signed [TEX_W-1:0] s_tex_u, s_tex_v;
    logic m_valid;
    logic m_ready;
    logic signed [OUT_W-1:0] m_tangent_x, m_tangent_y, m_tangent_z;
    logic signed [OUT_W-1:0] m_bitangent_x, m_bitangent_y, m_bitangent_z;
    logic signed [OUT_W-1:0] m_normal_x, m_normal_y, m_normal_z;
    logic m_degenerate;

    frame_t frames_due[$];
    longint held_pos [6];
    longint held_tex [4];
    int errors;
    int cycles;
    bit idle_on;

    triangle_tangent_frame_top i_dut (.*);

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    function automatic longint unsigned int_sqrt(longint unsigned x);
        longint unsigned r, b;
        r = 0;
        b = 64'd1 << 62;
        while (b > x) b >>= 2;
        while (b != 0) begin
            if (x >= r + b) begin
                x -= r + b;
                r = (r >> 1) + b;
            end else begin
                r >>= 1;
            end
            b >>= 2;
        end
        return r;
    endfunction

    function automatic bit normalize(input vec3_t c, output vec3_t u);
        longint unsigned m [3];
        longint unsigned mx, sum, s, q;
        int len;
        mx = 0;
        sum = 0;
        for (int i = 0; i < 3; i++) begin
            m[i] = (c[i] < 0) ? -c[i] : c[i];
            if (m[i] > mx) mx = m[i];
        end
        u = '{0, 0, 0};
        if (mx == 0) return 1'b0;
        len = 0;
        while (len < 64 && (mx >> len) != 0) len++;
        for (int i = 0; i < 3; i++) begin
            if (len > 30) m[i] >>= (len - 30);
            else m[i] <<= (30 - len);
            sum += m[i] * m[i];
        end
        s = int_sqrt(sum);
        for (int i = 0; i < 3; i++) begin
            q = ((m[i] << FRAC) + (s >> 1)) / s;
            u[i] = (c[i] < 0) ? -longint'(q) : longint'(q);
        end
        return 1'b1;
    endfunction

    function automatic frame_t tangent_frame(longint p [3], longint tu, longint tv);
        frame_t f;
        vec3_t e1, e2, tg, bn, nr, ut, ub, un;
        longint d1u, d1v, d2u, d2v, det;
        bit ok;
        for (int i = 0; i < 3; i++) begin
            e1[i] = held_pos[3+i] - held_pos[i];
            e2[i] = p[i] - held_pos[i];
        end
        d1u = held_tex[2] - held_tex[0];
        d1v = held_tex[3] - held_tex[1];
        d2u = tu - held_tex[0];
        d2v = tv - held_tex[1];
        det = d1u * d2v - d2u * d1v;
        for (int i = 0; i < 3; i++) begin
            tg[i] = d2v * e1[i] - d1v * e2[i];
            bn[i] = d1u * e2[i] - d2u * e1[i];
            if (det < 0) begin
                tg[i] = -tg[i];
                bn[i] = -bn[i];
            end
        end
        ok = (det != 0) && normalize(tg, ut) && normalize(bn, ub);
        if (ok) begin
            nr[0] = ut[1] * ub[2] - ut[2] * ub[1];
            nr[1] = ut[2] * ub[0] - ut[0] * ub[2];
            nr[2] = ut[0] * ub[1] - ut[1] * ub[0];
            ok = normalize(nr, un);
        end
        for (int i = 0; i < 3; i++) begin
            f.comp[i]   = ok ? OUT_W'(ut[i]) : '0;
            f.comp[3+i] = ok ? OUT_W'(ub[i]) : '0;
            f.comp[6+i] = ok ? OUT_W'(un[i]) : '0;
        end
        f.degen = !ok;
        return f;
    endfunction

    task automatic send_corner(logic [1:0] c, logic signed [31:0] px, py, pz,
                               logic signed [15:0] tu, tv);
        int gap;
        longint p [3];
        gap = idle_on ? $urandom_range(0, 7) : 0;
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid  <= 1'b1;
        s_corner <= c;
        s_pos_x  <= px;
        s_pos_y  <= py;
        s_pos_z  <= pz;
        s_tex_u  <= tu;
        s_tex_v  <= tv;
        do @(posedge aclk); while (!s_ready);
        p = '{px, py, pz};
        if (c == CORNER_FIRST || c == CORNER_SECOND) begin
            for (int i = 0; i < 3; i++) held_pos[c*3+i] = p[i];
            held_tex[c*2]   = tu;
            held_tex[c*2+1] = tv;
        end else if (c == CORNER_CLOSE) begin
            frames_due = {frames_due, tangent_frame(p, tu, tv)};
        end
    endtask

    function automatic logic signed [31:0] rand_pos();
        case ($urandom_range(0, 3))
            0: return $urandom;
            1: return $signed($urandom_range(0, 2000)) - 1000;
            2: return $signed($urandom) >>> $urandom_range(0, 31);
            default: return $signed($urandom_range(0, 65535)) << $urandom_range(0, 16);
        endcase
    endfunction

    function automatic logic signed [15:0] rand_tex();
        if ($urandom_range(0, 1)) return 16'($urandom);
        return 16'($signed($urandom_range(0, 200)) - 100);
    endfunction

    task automatic send_triangle(logic signed [31:0] p [9], logic signed [15:0] t [6]);
        send_corner(CORNER_FIRST, p[0], p[1], p[2], t[0], t[1]);
        send_corner(CORNER_SECOND, p[3], p[4], p[5], t[2], t[3]);
        send_corner(CORNER_CLOSE, p[6], p[7], p[8], t[4], t[5]);
    endtask

    task automatic test_basic_frames();
        send_triangle('{0, 0, 0, 32'h10000, 0, 0, 0, 32'h10000, 0},
                      '{0, 0, 16'h4000, 0, 0, 16'h4000});
        send_triangle('{0, 0, 0, 0, 32'h10000, 0, 32'h10000, 0, 0},
                      '{0, 0, 16'h4000, 0, 0, 16'h4000});
        send_triangle('{32'sh80000000, 32'sh80000000, 32'sh80000000,
                        32'sh7fffffff, 32'sh80000000, 32'sh7fffffff,
                        32'sh80000000, 32'sh7fffffff, 32'sh7fffffff},
                      '{16'sh8000, 16'sh8000, 16'sh7fff, 16'sh8000, 16'sh8000, 16'sh7fff});
        send_triangle('{32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff,
                        32'sh80000000, 32'sh7fffffff, 32'sh80000000,
                        32'sh7fffffff, 32'sh80000000, 0},
                      '{16'sh7fff, 16'sh7fff, 16'sh8000, 16'sh7fff, 16'sh7fff, 16'sh8000});
    endtask

    task automatic test_degenerate();
        send_triangle('{0, 0, 0, 100, 0, 0, 0, 100, 0}, '{5, 5, 5, 5, 9, 9});
        send_triangle('{7, 7, 7, 7, 7, 7, 7, 7, 7}, '{0, 0, 100, 0, 0, 100});
        send_triangle('{0, 0, 0, 100, 200, 300, 200, 400, 600}, '{0, 0, 100, 0, 0, 100});
    endtask

    task automatic test_dropped_and_reused();
        send_corner(CORNER_DROPPED, 32'sh7fffffff, 1, 2, 16'sh7fff, 3);
        send_corner(CORNER_CLOSE, 0, 0, 32'h30000, 0, 16'h2000);
        send_corner(CORNER_CLOSE, 32'h30000, 32'h1000, 0, 16'h2000, 16'h1000);
        send_corner(CORNER_DROPPED, 0, 0, 0, 0, 0);
    endtask

    task automatic test_random_triangles(int count);
        logic signed [31:0] p [9];
        logic signed [15:0] t [6];
        for (int n = 0; n < count; n++) begin
            if (n % 40 == 0) idle_on = ~idle_on;
            foreach (p[i]) p[i] = rand_pos();
            foreach (t[i]) t[i] = rand_tex();
            if ($urandom_range(0, 9) == 0) t[4] = t[0];
            if ($urandom_range(0, 9) == 0) begin
                t[4] = t[0];
                t[5] = t[1];
            end
            send_triangle(p, t);
        end
        idle_on = 1'b1;
    endtask

    task automatic test_corner_noise(int count);
        for (int n = 0; n < count; n++)
            send_corner(2'($urandom), rand_pos(), rand_pos(), rand_pos(),
                        rand_tex(), rand_tex());
    endtask

    initial begin
        m_ready = 1'b0;
        forever begin
            int stall;
            stall = idle_on ? $urandom_range(0, 7) : 0;
            if (stall > 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!m_valid);
        end
    end

    always @(posedge aclk) begin
        logic signed [OUT_W-1:0] got [9];
        frame_t want;
        if (aresetn && m_valid && m_ready) begin
            got = '{m_tangent_x, m_tangent_y, m_tangent_z,
                    m_bitangent_x, m_bitangent_y, m_bitangent_z,
                    m_normal_x, m_normal_y, m_normal_z};
            if (frames_due.size() == 0) begin
                $display("%0t: unexpected result transfer", $time);
                errors++;
            end else begin
                want = frames_due.pop_front();
                for (int i = 0; i < 9; i++)
                    if (got[i] !== want.comp[i]) begin
                        $display("%0t: component %0d expected %0d got %0d",
                                 $time, i, want.comp[i], got[i]);
                        errors++;
                    end
                if (m_degenerate !== want.degen) begin
                    $display("%0t: degenerate expected %0b got %0b",
                             $time, want.degen, m_degenerate);
                    errors++;
                end
            end
        end
    end

    always @(posedge aclk) begin
        cycles++;
        if (cycles >= CYCLE_LIMIT) begin
            $display("triangle_tangent_frame_top_tb: FAIL");
            $finish;
        end
    end

    initial begin
        int drain;
        errors   = 0;
        cycles   = 0;
        idle_on  = 1'b1;
        aresetn  = 1'b0;
        s_valid  = 1'b0;
        s_corner = '0;
        s_pos_x  = '0;
        s_pos_y  = '0;
        s_pos_z  = '0;
        s_tex_u  = '0;
        s_tex_v  = '0;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_basic_frames();
        test_degenerate();
        test_dropped_and_reused();
        test_random_triangles(190);
        test_corner_noise(60);
        s_valid <= 1'b0;
        while (frames_due.size() != 0) @(posedge aclk);
        drain = 0;
        while (drain < 400) begin
            @(posedge aclk);
            drain++;
        end
        if (errors == 0)
            $display("triangle_tangent_frame_top_tb: PASS");
        else
            $display("triangle_tangent_frame_top_tb: FAIL");
        $finish;
    end
endmodule
